>>> design/sft_pkg.sv
// ----------------------------------------------------------------------------
// SMT fetch thread selector package
// Shared types, field widths, register indexes and mode codes.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int unsigned THREADS_DEF = 4;
  localparam int unsigned NFIELDS     = 4;

  localparam int unsigned FILL_W    = 10;
  localparam int unsigned RET_W     = 32;
  localparam int unsigned SHARE_W   = 5;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned STALL_W   = 8;
  localparam int unsigned CYC_W     = 21;
  localparam int unsigned QUANTUM_W = 20;
  localparam int unsigned PTR_OUT_W = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CYC_W-1:0] CYC_MAX    = {CYC_W{1'b1}};
  localparam logic [RET_W:0]   FAIR_LIMIT = 33'd100000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FETCH_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FETCH_POLICY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FETCH_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROB_SIZE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_QUANTUM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_PENALTY = 3'd5;

  // Fetch kinds and policies.
  localparam logic [1:0] KIND_MULTI  = 2'd0;
  localparam logic [1:0] KIND_SOE    = 2'd1;
  localparam logic [1:0] KIND_SLICE  = 2'd2;
  localparam logic       POLICY_ICOUNT = 1'b0;
  localparam logic       POLICY_EQUAL  = 1'b1;

  // Register reset values.
  localparam logic [1:0]           RST_FETCH_KIND     = KIND_MULTI;
  localparam logic                 RST_FETCH_POLICY   = POLICY_ICOUNT;
  localparam logic [SHARE_W-1:0]   RST_FETCH_WIDTH    = 5'd4;
  localparam logic [FILL_W-1:0]    RST_ROB_SIZE       = 10'd64;
  localparam logic [QUANTUM_W-1:0] RST_SWITCH_QUANTUM = 20'd1000;
  localparam logic [STALL_W-1:0]   RST_SWITCH_PENALTY = 8'd0;

  typedef struct packed {
    logic [1:0]           fetch_kind;
    logic                 fetch_policy;
    logic [SHARE_W-1:0]   fetch_width;
    logic [FILL_W-1:0]    rob_size;
    logic [QUANTUM_W-1:0] switch_quantum;
    logic [STALL_W-1:0]   switch_penalty;
    logic [FILL_W-1:0]    thr_hi;   // rob_size * 3 / 4
    logic [FILL_W-1:0]    thr_mid;  // rob_size * 2 / 4
  } cfg_t;

  typedef struct packed {
    logic [3:0]        ready_mask;
    logic [3:0]        running_mask;
    logic [3:0]        longlat_mask;
    logic [FILL_W-1:0] rob_fill_0;
    logic [FILL_W-1:0] rob_fill_1;
    logic [FILL_W-1:0] rob_fill_2;
    logic [FILL_W-1:0] rob_fill_3;
    logic [RET_W-1:0]  retired_0;
    logic [RET_W-1:0]  retired_1;
    logic [RET_W-1:0]  retired_2;
    logic [RET_W-1:0]  retired_3;
  } in_word_t;

  typedef struct packed {
    logic [SHARE_W-1:0]   share_0;
    logic [SHARE_W-1:0]   share_1;
    logic [SHARE_W-1:0]   share_2;
    logic [SHARE_W-1:0]   share_3;
    logic [PTR_OUT_W-1:0] pointer_thread;
    logic                 none_fetchable;
  } out_word_t;

endpackage

>>> design/sft_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one word per handshake; source drives valid and data, sink ready.
// ----------------------------------------------------------------------------
interface sft_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/smt_fetch_thread_selector_core.sv
// ----------------------------------------------------------------------------
// SMT fetch thread selector
// Shares the fetch width among hardware threads once per processor cycle.
// ----------------------------------------------------------------------------
// Flow: a word is accepted in S_IDLE; the pointer then visits threads in S_GRANT,
// S_SEARCH or S_SLICE as the fetch kind needs, and the result word sits in the
// output register until taken. ICOUNT and equal round robin visit until the fetch
// width is spent; switch on event searches for a new thread; timeslice steps to
// the next fetchable thread. One word is in flight over the single grant/compare unit.
// Reset is asynchronous: pointer, stall and cycle counters clear, registers
// return to their defaults.
module smt_fetch_thread_selector_core
  import sft_pkg::*;
#(
  parameter int unsigned THREADS = THREADS_DEF
)
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sft_stream_if.sink            in_i,
  sft_stream_if.source          out_o
);

  localparam int unsigned PTR_W = $clog2(THREADS);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(THREADS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GRANT  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SLICE  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  cfg_t cfg;

  sft_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Per-thread view of the input word; threads without fields read as idle.
  logic [THREADS-1:0]             rdy_w, run_w, lng_w;
  logic [THREADS-1:0][FILL_W-1:0] fill_w;
  logic [THREADS-1:0][RET_W-1:0]  ret_w;
  logic [NFIELDS-1:0][FILL_W-1:0] fill_in;
  logic [NFIELDS-1:0][RET_W-1:0]  ret_in;

  assign fill_in[0] = in_i.data.rob_fill_0;
  assign fill_in[1] = in_i.data.rob_fill_1;
  assign fill_in[2] = in_i.data.rob_fill_2;
  assign fill_in[3] = in_i.data.rob_fill_3;
  assign ret_in[0]  = in_i.data.retired_0;
  assign ret_in[1]  = in_i.data.retired_1;
  assign ret_in[2]  = in_i.data.retired_2;
  assign ret_in[3]  = in_i.data.retired_3;

  for (genvar t = 0; t < THREADS; t++) begin : g_fields
    if (t < NFIELDS) begin : g_live
      assign rdy_w[t]  = in_i.data.ready_mask[t];
      assign run_w[t]  = in_i.data.running_mask[t];
      assign lng_w[t]  = in_i.data.longlat_mask[t];
      assign fill_w[t] = fill_in[t];
      assign ret_w[t]  = ret_in[t];
    end else begin : g_idle
      assign rdy_w[t]  = 1'b0;
      assign run_w[t]  = 1'b0;
      assign lng_w[t]  = 1'b0;
      assign fill_w[t] = '0;
      assign ret_w[t]  = '0;
    end
  end

  logic [2:0]                      state_q, state_d;
  logic [PTR_W-1:0]                ptr_q, ptr_d, cand_q, cand_d;
  logic [THREADS-1:0][STALL_W-1:0] stall_q, stall_d;
  logic [CYC_W-1:0]                cyc_q, cyc_d;
  logic [THREADS-1:0][SHARE_W-1:0] quant_q, quant_d;
  logic [THREADS-1:0][LVL_W-1:0]   lvl_q, lvl_d;
  logic [THREADS-1:0]              can_q, can_d;
  logic [SHARE_W-1:0]              total_q, total_d;
  logic                            must_q, must_d;
  logic                            none_q, none_d;
  logic [THREADS-1:0]              lng_q;
  logic [THREADS-1:0][RET_W-1:0]   ret_q;
  logic [RET_W-1:0]                ret_cur_q;

  // Accept-cycle evaluation: stall countdown, fetchable set and grant levels (ICOUNT or equal).
  logic [THREADS-1:0][STALL_W-1:0] stall_dec;
  logic [THREADS-1:0]              can_w;
  logic [THREADS-1:0][LVL_W-1:0]   lvl_w;
  logic                            any_can, any_lvl, soe_trigger;

  always_comb begin
    any_can = 1'b0;
    any_lvl = 1'b0;
    for (int t = 0; t < THREADS; t++) begin
      stall_dec[t] = (stall_q[t] != '0) ? stall_q[t] - STALL_W'(1) : stall_q[t];
      can_w[t]     = rdy_w[t] && (stall_dec[t] == '0);
      if (!can_w[t]) begin
        lvl_w[t] = 2'd0;
      end else if (cfg.fetch_policy == POLICY_EQUAL) begin
        lvl_w[t] = 2'd1;
      end else if (fill_w[t] > cfg.thr_hi) begin
        lvl_w[t] = 2'd0;
      end else if (fill_w[t] > cfg.thr_mid) begin
        lvl_w[t] = 2'd1;
      end else begin
        lvl_w[t] = 2'd2;
      end
      any_can = any_can | can_w[t];
      any_lvl = any_lvl | (lvl_w[t] != 2'd0);
    end
    soe_trigger = (cyc_q > {1'b0, cfg.switch_quantum}) || lng_w[ptr_q] || !run_w[ptr_q];
  end

  logic [PTR_W-1:0]   ptr_nx, cand_nx;
  logic [SHARE_W-1:0] lvl_ext, cut;
  logic               unfair;

  assign ptr_nx  = (ptr_q == LAST) ? '0 : ptr_q + PTR_W'(1);
  assign cand_nx = (cand_q == LAST) ? '0 : cand_q + PTR_W'(1);
  assign lvl_ext = {3'b000, lvl_q[ptr_nx]};
  assign cut     = (lvl_ext > total_q) ? total_q : lvl_ext;
  assign unfair  = {1'b0, ret_q[cand_q]} > ({1'b0, ret_cur_q} + FAIR_LIMIT);

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cand_d  = cand_q;
    stall_d = stall_q;
    cyc_d   = cyc_q;
    quant_d = quant_q;
    lvl_d   = lvl_q;
    can_d   = can_q;
    total_d = total_q;
    must_d  = must_q;
    none_d  = none_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          stall_d = stall_dec;
          cyc_d   = (cyc_q == CYC_MAX) ? cyc_q : cyc_q + CYC_W'(1);
          quant_d = '0;
          can_d   = can_w;
          lvl_d   = lvl_w;
          total_d = cfg.fetch_width;
          none_d  = 1'b0;
          state_d = S_OUT;
          if (!any_can) begin
            none_d = 1'b1;
          end else begin
            unique case (cfg.fetch_kind)
              KIND_MULTI: begin
                if (!any_lvl) begin
                  none_d = 1'b1;
                end else if (cfg.fetch_width != '0) begin
                  state_d = S_GRANT;
                end
              end
              KIND_SOE: begin
                if (soe_trigger) begin
                  cand_d  = ptr_nx;
                  must_d  = !run_w[ptr_q];
                  state_d = S_SEARCH;
                end else if (can_w[ptr_q]) begin
                  quant_d[ptr_q] = cfg.fetch_width;
                end
              end
              KIND_SLICE: state_d = S_SLICE;
              default: ;
            endcase
          end
        end
      end
      S_GRANT: begin
        // One thread visited per cycle; its level is cut to the slots left.
        ptr_d = ptr_nx;
        if (lvl_ext != '0) begin
          quant_d[ptr_nx] = quant_q[ptr_nx] + cut;
          lvl_d[ptr_nx]   = cut[LVL_W-1:0];
          total_d         = total_q - cut;
          if (total_q == cut) begin
            state_d = S_OUT;
          end
        end
      end
      S_SEARCH: begin
        if (cand_q == ptr_q) begin
          if (can_q[ptr_q]) begin
            quant_d[ptr_q] = cfg.fetch_width;
          end
          state_d = S_OUT;
        end else if (can_q[cand_q] && (must_q || (!unfair && !lng_q[cand_q]))) begin
          // Switch: the new thread starts with the penalty as its stall.
          ptr_d          = cand_q;
          stall_d[cand_q] = cfg.switch_penalty;
          cyc_d          = CYC_W'(1);
          if (cfg.switch_penalty == '0) begin
            quant_d[cand_q] = cfg.fetch_width;
          end
          state_d = S_OUT;
        end else begin
          cand_d = cand_nx;
        end
      end
      S_SLICE: begin
        ptr_d = ptr_nx;
        if (can_q[ptr_nx]) begin
          quant_d[ptr_nx] = cfg.fetch_width;
          state_d         = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      cand_q  <= '0;
      stall_q <= '0;
      cyc_q   <= '0;
      quant_q <= '0;
      lvl_q   <= '0;
      can_q   <= '0;
      total_q <= '0;
      must_q  <= 1'b0;
      none_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cand_q  <= cand_d;
      stall_q <= stall_d;
      cyc_q   <= cyc_d;
      quant_q <= quant_d;
      lvl_q   <= lvl_d;
      can_q   <= can_d;
      total_q <= total_d;
      must_q  <= must_d;
      none_q  <= none_d;
    end
  end

  // Word payload captured at accept for the switch-on-event search.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      lng_q     <= lng_w;
      ret_q     <= ret_w;
      ret_cur_q <= ret_w[ptr_q];
    end
  end

  logic [NFIELDS-1:0][SHARE_W-1:0] share_w;

  for (genvar t = 0; t < NFIELDS; t++) begin : g_share
    if (t < THREADS) begin : g_on
      assign share_w[t] = quant_q[t];
    end else begin : g_off
      assign share_w[t] = '0;
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);

  always_comb begin
    out_o.data.share_0        = share_w[0];
    out_o.data.share_1        = share_w[1];
    out_o.data.share_2        = share_w[2];
    out_o.data.share_3        = share_w[3];
    out_o.data.pointer_thread = PTR_OUT_W'(ptr_q);
    out_o.data.none_fetchable = none_q;
  end

endmodule

>>> design/sft_cfg_regs.sv
// ----------------------------------------------------------------------------
// Fetch selector configuration registers
// Write-only register file with the ICOUNT occupancy thresholds derived.
// ----------------------------------------------------------------------------
module sft_cfg_regs
  import sft_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  logic [1:0]           kind_q;
  logic                 policy_q;
  logic [SHARE_W-1:0]   width_q;
  logic [FILL_W-1:0]    rob_q;
  logic [QUANTUM_W-1:0] quantum_q;
  logic [STALL_W-1:0]   penalty_q;
  logic [FILL_W+1:0]    rob_x3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= RST_FETCH_KIND;
      policy_q  <= RST_FETCH_POLICY;
      width_q   <= RST_FETCH_WIDTH;
      rob_q     <= RST_ROB_SIZE;
      quantum_q <= RST_SWITCH_QUANTUM;
      penalty_q <= RST_SWITCH_PENALTY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FETCH_KIND:     kind_q    <= cfg_wdata_i[1:0];
        CFG_FETCH_POLICY:   policy_q  <= cfg_wdata_i[0];
        CFG_FETCH_WIDTH:    width_q   <= cfg_wdata_i[SHARE_W-1:0];
        CFG_ROB_SIZE:       rob_q     <= cfg_wdata_i[FILL_W-1:0];
        CFG_SWITCH_QUANTUM: quantum_q <= cfg_wdata_i[QUANTUM_W-1:0];
        CFG_SWITCH_PENALTY: penalty_q <= cfg_wdata_i[STALL_W-1:0];
        default: ;
      endcase
    end
  end

  assign rob_x3 = {2'b00, rob_q} + {1'b0, rob_q, 1'b0};

  always_comb begin
    cfg_o.fetch_kind     = kind_q;
    cfg_o.fetch_policy   = policy_q;
    cfg_o.fetch_width    = width_q;
    cfg_o.rob_size       = rob_q;
    cfg_o.switch_quantum = quantum_q;
    cfg_o.switch_penalty = penalty_q;
    cfg_o.thr_hi         = rob_x3[FILL_W+1:2];
    cfg_o.thr_mid        = {1'b0, rob_q[FILL_W-1:1]};
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SMT fetch thread selector testbench
// Drives processor-cycle words in and checks each grant word against a typed
// expected word or a cycle-level predictor of the fetch share-out, across all
// fetch kinds and a range of register settings, stalling both sides at random.
// ----------------------------------------------------------------------------
module tb;
  import sft_pkg::*;

  localparam int unsigned THREADS     = THREADS_DEF;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_WORDS = 112;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SETTLE      = 150;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [39:0]  FILLS_ZERO = '0;
  localparam logic [39:0]  FILLS_FULL = {4{10'd1023}};
  localparam logic [127:0] RETS_ZERO  = '0;
  localparam logic [127:0] RETS_MAX   = '1;
  localparam out_word_t    NO_GRANT   = '0;

  typedef enum logic {ROW_CYCLE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_word_t              w;
    logic                  typed;
    out_word_t             res;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sft_stream_if #(.data_t(in_word_t))  cycle_in ();
  sft_stream_if #(.data_t(out_word_t)) grant_out ();

  smt_fetch_thread_selector_core #(
    .THREADS(THREADS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (cycle_in),
    .out_o      (grant_out)
  );

  // Register copies and selector state as the predictor sees them.
  logic [1:0]           m_kind     = RST_FETCH_KIND;
  logic                 m_policy   = RST_FETCH_POLICY;
  logic [SHARE_W-1:0]   m_width    = RST_FETCH_WIDTH;
  logic [FILL_W-1:0]    m_rob      = RST_ROB_SIZE;
  logic [QUANTUM_W-1:0] m_quantum  = RST_SWITCH_QUANTUM;
  logic [STALL_W-1:0]   m_penalty  = RST_SWITCH_PENALTY;
  int unsigned          sel_ptr    = 0;
  logic [STALL_W-1:0]   hold_cnt [THREADS] = '{default: '0};
  logic [CYC_W-1:0]     since_switch = '0;

  out_word_t   grant_q [$];
  int unsigned bad_grants   = 0;
  int unsigned quiet_cycles = 0;
  bit          in_calm      = 0;
  bit          out_calm     = 0;
  int unsigned out_hold     = 0;
  plan_row_t   plan [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned next_thr(int unsigned t);
    return (t + 1) % THREADS;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One processor cycle of the selector: stall countdown, then the share-out.
  function automatic out_word_t share_fetch(input in_word_t w);
    logic [FILL_W-1:0] fill [THREADS];
    logic [RET_W-1:0]  ret [THREADS];
    bit                can [THREADS];
    int unsigned       lvl [THREADS];
    int unsigned       slots [THREADS];
    int unsigned       n_can, left, hi, mid, cur, cand;
    bit                must, moved, none;
    out_word_t         r;
    fill  = '{w.rob_fill_0, w.rob_fill_1, w.rob_fill_2, w.rob_fill_3};
    ret   = '{w.retired_0, w.retired_1, w.retired_2, w.retired_3};
    n_can = 0;
    moved = 0;
    none  = 0;
    hi    = (32'(m_rob) * 3) / 4;
    mid   = (32'(m_rob) * 2) / 4;
    for (int t = 0; t < THREADS; t++) begin
      if (hold_cnt[t] != 0) hold_cnt[t] = hold_cnt[t] - 1'b1;
      can[t]   = w.ready_mask[t] && hold_cnt[t] == 0;
      slots[t] = 0;
      lvl[t]   = 0;
      if (can[t]) n_can++;
    end

    if (n_can == 0) begin
      none = 1;
    end else if (m_kind == KIND_MULTI && m_policy == POLICY_ICOUNT) begin
      for (int t = 0; t < THREADS; t++) begin
        if (can[t]) begin
          if (fill[t] > hi) begin
            can[t] = 0;
            n_can--;
          end else if (fill[t] > mid) begin
            lvl[t] = 1;
          end else begin
            lvl[t] = 2;
          end
        end
      end
      if (n_can == 0) begin
        none = 1;
      end else begin
        // A level cut short by the remaining width stays cut for later visits.
        left = m_width;
        while (left != 0) begin
          sel_ptr = next_thr(sel_ptr);
          if (lvl[sel_ptr] != 0) begin
            if (lvl[sel_ptr] > left) lvl[sel_ptr] = left;
            slots[sel_ptr] += lvl[sel_ptr];
            left -= lvl[sel_ptr];
          end
        end
      end
    end else if (m_kind == KIND_MULTI) begin
      left = m_width;
      while (left != 0) begin
        sel_ptr = next_thr(sel_ptr);
        if (can[sel_ptr]) begin
          slots[sel_ptr]++;
          left--;
        end
      end
    end else if (m_kind == KIND_SOE) begin
      cur  = sel_ptr;
      must = !w.running_mask[cur];
      if (since_switch > m_quantum || w.longlat_mask[cur] || must) begin
        cand = next_thr(cur);
        while (cand != cur) begin
          if (can[cand]) begin
            if (must) break;
            if (64'(ret[cand]) <= 64'(ret[cur]) + 64'(FAIR_LIMIT) &&
                !w.longlat_mask[cand]) break;
          end
          cand = next_thr(cand);
        end
        if (cand != cur) begin
          sel_ptr        = cand;
          moved          = 1;
          hold_cnt[cand] = m_penalty;
        end
      end
      if (can[sel_ptr] && hold_cnt[sel_ptr] == 0) slots[sel_ptr] = m_width;
    end else if (m_kind == KIND_SLICE) begin
      for (int i = 0; i < THREADS; i++) begin
        sel_ptr = next_thr(sel_ptr);
        if (can[sel_ptr]) break;
      end
      slots[sel_ptr] = m_width;
    end

    if (moved) since_switch = '0;
    if (since_switch != CYC_MAX) since_switch = since_switch + 1'b1;

    r.share_0        = SHARE_W'(slots[0]);
    r.share_1        = SHARE_W'(slots[1]);
    r.share_2        = SHARE_W'(slots[2]);
    r.share_3        = SHARE_W'(slots[3]);
    r.pointer_thread = PTR_OUT_W'(sel_ptr);
    r.none_fetchable = none;
    return r;
  endfunction

  // Random cycle word, biased toward the ICOUNT thresholds and the fairness
  // limit so that every branch of the share-out is reached often.
  function automatic in_word_t rand_word();
    logic [FILL_W-1:0] fill [THREADS];
    logic [RET_W-1:0]  ret [THREADS];
    logic [RET_W-1:0]  base;
    int                v;
    int unsigned       th;
    in_word_t          w;
    case ($urandom_range(0, 9))
      0:       w.ready_mask = '0;
      1, 2:    w.ready_mask = 4'($urandom_range(0, 15));
      default: for (int t = 0; t < 4; t++) w.ready_mask[t] = $urandom_range(0, 3) != 0;
    endcase
    for (int t = 0; t < 4; t++) begin
      w.running_mask[t] = $urandom_range(0, 7) != 0;
      w.longlat_mask[t] = $urandom_range(0, 5) == 0;
    end
    base = $urandom();
    for (int t = 0; t < THREADS; t++) begin
      case ($urandom_range(0, 3))
        0: fill[t] = FILL_W'($urandom_range(0, 1023));
        1, 2: begin
          th = ($urandom_range(0, 1) != 0) ? (32'(m_rob) * 3) / 4 : (32'(m_rob) * 2) / 4;
          v  = int'(th) + int'($urandom_range(0, 2)) - 1;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
          fill[t] = FILL_W'(v);
        end
        default: fill[t] = ($urandom_range(0, 1) != 0) ? '1 : '0;
      endcase
      case ($urandom_range(0, 5))
        0:       ret[t] = $urandom();
        1, 2:    ret[t] = base + $urandom_range(0, 150000);
        3:       ret[t] = base + RET_W'(FAIR_LIMIT) + $urandom_range(0, 1);
        4:       ret[t] = base - $urandom_range(0, 50000);
        default: ret[t] = ($urandom_range(0, 1) != 0) ? '1 : '0;
      endcase
    end
    w.rob_fill_0 = fill[0];
    w.rob_fill_1 = fill[1];
    w.rob_fill_2 = fill[2];
    w.rob_fill_3 = fill[3];
    w.retired_0  = ret[0];
    w.retired_1  = ret[1];
    w.retired_2  = ret[2];
    w.retired_3  = ret[3];
    return w;
  endfunction

  function automatic plan_row_t cycle_row(logic [11:0] masks, logic [39:0] fills,
                                          logic [127:0] rets, logic typed,
                                          out_word_t res);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_CYCLE;
    r.w     = {masks, fills, rets};
    r.typed = typed;
    r.res   = res;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // Sends one cycle word and queues its grant once the word is taken.
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t res);
    out_word_t   pred;
    int unsigned gap;
    cfg_we_i      <= 1'b0;
    cycle_in.valid <= 1'b1;
    cycle_in.data  <= w;
    do @(posedge clk_i); while (!cycle_in.ready);
    pred = share_fetch(w);
    grant_q.push_back(typed ? res : pred);
    gap = in_calm ? 0 : idle_len();
    if (gap != 0) begin
      cycle_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Registers change only once every grant in flight has come back.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cycle_in.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_FETCH_KIND:     m_kind    = val[1:0];
      CFG_FETCH_POLICY:   m_policy  = val[0];
      CFG_FETCH_WIDTH:    m_width   = val[SHARE_W-1:0];
      CFG_ROB_SIZE:       m_rob     = val[FILL_W-1:0];
      CFG_SWITCH_QUANTUM: m_quantum = val[QUANTUM_W-1:0];
      CFG_SWITCH_PENALTY: m_penalty = val[STALL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic flag_grant(input string msg);
    bad_grants++;
    if (bad_grants <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Output side: ready drops for random stretches, with calm stretches too.
  initial begin
    grant_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
      if (out_hold != 0) begin
        grant_out.ready <= 1'b0;
        out_hold--;
      end else begin
        grant_out.ready <= 1'b1;
        out_hold = out_calm ? 0 : idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want, got;
    if (rst_ni) begin
      if (grant_out.valid && grant_out.ready) begin
        got = grant_out.data;
        if (grant_q.size() == 0) begin
          flag_grant($sformatf("unexpected grant word %h", got));
        end else begin
          want = grant_q.pop_front();
          if (got.share_0 !== want.share_0 || got.share_1 !== want.share_1 ||
              got.share_2 !== want.share_2 || got.share_3 !== want.share_3 ||
              got.pointer_thread !== want.pointer_thread ||
              got.none_fetchable !== want.none_fetchable) begin
            flag_grant($sformatf(
              "grant mismatch: want %0d/%0d/%0d/%0d ptr %0d none %0d, got %0d/%0d/%0d/%0d ptr %0d none %0d",
              want.share_0, want.share_1, want.share_2, want.share_3,
              want.pointer_thread, want.none_fetchable,
              got.share_0, got.share_1, got.share_2, got.share_3,
              got.pointer_thread, got.none_fetchable));
          end
        end
      end
      if ((cycle_in.valid && cycle_in.ready) || (grant_out.valid && grant_out.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]            kind_v;
    logic                  policy_v;
    logic [CFG_DATA_W-1:0] width_v, rob_v, quantum_v, penalty_v;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_wdata_i    <= '0;
    cycle_in.valid <= 1'b0;
    cycle_in.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ICOUNT at the reset settings: width 4, thresholds 48 and 32.
    plan.push_back(cycle_row({4'h0, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 1'b1}));
    plan.push_back(cycle_row({4'h1, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd4, 5'd0, 5'd0, 5'd0, 2'd0, 1'b0}));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd2, 5'd2, 5'd0, 2'd2, 1'b0}));
    // Every thread above three quarters of the buffer is shut out.
    plan.push_back(cycle_row({4'hF, 4'hF, 4'hF}, FILLS_FULL, RETS_MAX, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd2, 1'b1}));
    plan.push_back(cycle_row({4'hF, 4'h0, 4'h0}, {10'd33, 10'd48, 10'd49, 10'd32},
                             RETS_ZERO, 0, NO_GRANT));
    plan.push_back(reg_row(CFG_FETCH_WIDTH, 20'd0));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd1, 1'b0}));
    plan.push_back(reg_row(CFG_FETCH_POLICY, 20'(POLICY_EQUAL)));
    plan.push_back(reg_row(CFG_FETCH_WIDTH, 20'd16));
    plan.push_back(cycle_row({4'h5, 4'hF, 4'h0}, FILLS_FULL, RETS_ZERO, 1,
                             {5'd8, 5'd0, 5'd8, 5'd0, 2'd0, 1'b0}));
    plan.push_back(reg_row(CFG_FETCH_WIDTH, 20'd0));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 1'b0}));
    // The spare kind code grants nothing and leaves the pointer alone.
    plan.push_back(reg_row(CFG_FETCH_KIND, 20'(KIND_UNUSED)));
    plan.push_back(reg_row(CFG_FETCH_WIDTH, 20'd7));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 1'b0}));
    plan.push_back(cycle_row({4'h0, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 1'b1}));
    plan.push_back(reg_row(CFG_FETCH_KIND, 20'(KIND_SLICE)));
    plan.push_back(reg_row(CFG_FETCH_WIDTH, 20'd16));
    plan.push_back(cycle_row({4'h8, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd16, 2'd3, 1'b0}));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd16, 5'd0, 5'd0, 5'd0, 2'd0, 1'b0}));
    // Switch on event: a thread that stops running forces a switch, and the
    // new thread sits out its penalty before it fetches.
    plan.push_back(reg_row(CFG_FETCH_KIND, 20'(KIND_SOE)));
    plan.push_back(reg_row(CFG_FETCH_WIDTH, 20'd8));
    plan.push_back(reg_row(CFG_SWITCH_PENALTY, 20'd2));
    plan.push_back(reg_row(CFG_SWITCH_QUANTUM, 20'hFFFFF));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd8, 5'd0, 5'd0, 5'd0, 2'd0, 1'b0}));
    plan.push_back(cycle_row({4'hF, 4'hE, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd1, 1'b0}));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd0, 5'd0, 5'd0, 2'd1, 1'b0}));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 1,
                             {5'd0, 5'd8, 5'd0, 5'd0, 2'd1, 1'b0}));
    // Long latency on the current thread; thread 2 is too far ahead to be fair.
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h2}, FILLS_ZERO,
                             {32'd0, 32'd0, 32'd200000, 32'd50000}, 0, NO_GRANT));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'hF}, FILLS_ZERO, RETS_ZERO, 0, NO_GRANT));
    plan.push_back(reg_row(CFG_SWITCH_QUANTUM, 20'd0));
    plan.push_back(reg_row(CFG_SWITCH_PENALTY, 20'd0));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 0, NO_GRANT));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO,
                             {32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0}, 0, NO_GRANT));
    plan.push_back(cycle_row({4'hF, 4'hF, 4'h0}, FILLS_ZERO,
                             {32'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF}, 0, NO_GRANT));
    plan.push_back(cycle_row({4'h0, 4'hF, 4'h0}, FILLS_ZERO, RETS_ZERO, 0, NO_GRANT));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) cfg_write(plan[i].idx, plan[i].val);
      else send_word(plan[i].w, plan[i].typed, plan[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0:       begin kind_v = KIND_MULTI; policy_v = POLICY_ICOUNT; end
        1:       begin kind_v = KIND_MULTI; policy_v = POLICY_EQUAL;  end
        2:       begin kind_v = KIND_SOE;   policy_v = 1'($urandom_range(0, 1)); end
        default: begin kind_v = KIND_SLICE; policy_v = 1'($urandom_range(0, 1)); end
      endcase
      if (ph == 0 || ph == 2 || ph == 5) width_v = 20'd16;
      else if (ph == 1 || ph == 6 || ph == 7) width_v = 20'd1;
      else width_v = 20'($urandom_range(1, 16));
      if (ph == 0 || ph == 9) rob_v = 20'd1023;
      else if (ph == 4) rob_v = 20'd1;
      else rob_v = 20'($urandom_range(8, 1023));
      case (ph)
        2:       begin quantum_v = 20'd0;     penalty_v = 20'd255; end
        6:       begin quantum_v = 20'hFFFFF; penalty_v = 20'd0;   end
        10:      begin quantum_v = 20'($urandom_range(0, 200));
                       penalty_v = 20'($urandom_range(0, 8)); end
        default: begin quantum_v = 20'($urandom_range(0, 60));
                       penalty_v = 20'($urandom_range(0, 255)); end
      endcase
      cfg_write(CFG_FETCH_KIND, 20'(kind_v));
      cfg_write(CFG_FETCH_POLICY, 20'(policy_v));
      cfg_write(CFG_FETCH_WIDTH, width_v);
      cfg_write(CFG_ROB_SIZE, rob_v);
      cfg_write(CFG_SWITCH_QUANTUM, quantum_v);
      cfg_write(CFG_SWITCH_PENALTY, penalty_v);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 149) == 0) in_calm = !in_calm;
        send_word(rand_word(), 0, NO_GRANT);
      end
    end

    cycle_in.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (bad_grants == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
